/* rtl/rrqs_pkg.sv */
// Shared types and constants for the round-robin quantum scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
package rrqs_pkg;

  localparam int unsigned PID_W     = 4;
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned OUT_T_W   = 16;
  localparam int unsigned QUANTUM_W = 8;
  localparam int unsigned SLICE_W   = 8;

  localparam logic FUNC_ADMIT = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic [1:0] ST_TICK       = 2'd0;
  localparam logic [1:0] ST_ACCEPT     = 2'd1;
  localparam logic [1:0] ST_DUPLICATE  = 2'd2;
  localparam logic [1:0] ST_ZERO_BURST = 2'd3;

  localparam logic REG_QUANTUM = 1'b0;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd4;

  typedef struct packed {
    logic admit;
    logic tick;
    logic fetch_head;
    logic fetch_entry;
    logic load_entry;
    logic execute;
  } cmd_t;

  typedef struct packed {
    logic pop_needed;
  } sts_t;

endpackage

/* rtl/rrqs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrqs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rrqs_ctrl.sv */
// Sequencer for the scheduler: accepts items and steps a tick through dispatch.
// Depends on rrqs_pkg.
module rrqs_ctrl import rrqs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic func_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HEAD  = 3'd1;
  localparam logic [2:0] S_ENTRY = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       take;

  assign take = (state_q == S_IDLE) && start_i;

  always_comb begin
    cmd_o.admit       = take && (func_i == FUNC_ADMIT);
    cmd_o.tick        = take && (func_i == FUNC_TICK);
    cmd_o.fetch_head  = (state_q == S_HEAD);
    cmd_o.fetch_entry = (state_q == S_ENTRY);
    cmd_o.load_entry  = (state_q == S_LOAD);
    cmd_o.execute     = (state_q == S_EXEC);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take && (func_i == FUNC_TICK)) begin
          state_d = sts_i.pop_needed ? S_HEAD : S_EXEC;
        end
      end
      S_HEAD:  state_d = S_ENTRY;
      S_ENTRY: state_d = S_LOAD;
      S_LOAD:  state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* rtl/rrqs_datapath.sv */
// Scheduler datapath: ready queue, process table, running context, result beat.
// Depends on rrqs_pkg and rrqs_ram.
module rrqs_datapath import rrqs_pkg::*; #(
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [PID_W-1:0]     pid_i,
  input  logic [BURST_W-1:0]   burst_i,
  input  logic [QUANTUM_W-1:0] quantum_i,
  output sts_t                 sts_o,
  output logic                 res_valid_o,
  output logic [1:0]           admit_status_o,
  output logic                 idle_o,
  output logic [PID_W-1:0]     run_pid_o,
  output logic                 done_res_o,
  output logic [PID_W-1:0]     done_pid_o,
  output logic [OUT_T_W-1:0]   waiting_time_o,
  output logic [OUT_T_W-1:0]   turnaround_time_o,
  output logic [OUT_T_W-1:0]   now_o
);

  localparam int unsigned PW = $clog2(MAX_PROCS);
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);
  localparam int unsigned EW = TIME_BITS + 2 * BURST_W;
  localparam int unsigned WW = (TIME_BITS > BURST_W) ? TIME_BITS : BURST_W;

  // ready queue
  logic [PW-1:0]        head_q, tail_q;
  logic [CW-1:0]        count_q;
  logic                 fifo_we, fifo_full;
  logic [PW-1:0]        fifo_wdata, fifo_rdata;

  // process table
  logic                 tab_we;
  logic [PW-1:0]        tab_waddr;
  logic [EW-1:0]        tab_wdata, tab_rdata;

  // running context
  logic [MAX_PROCS-1:0] admitted_q;
  logic [TIME_BITS-1:0] clock_q, clock_d;
  logic                 run_valid_q;
  logic [PW-1:0]        run_pid_q;
  logic [TIME_BITS-1:0] run_arr_q;
  logic [BURST_W-1:0]   run_burst_q;
  logic [BURST_W-1:0]   run_rem_q, rem_next;
  logic [SLICE_W-1:0]   slice_q;

  logic [QUANTUM_W-1:0] q_eff;
  logic                 preempt, pid_ok, dup, admit_ok, finish;
  logic [PW-1:0]        pid_idx;
  logic [TIME_BITS-1:0] ta;
  logic [WW-1:0]        ta_w, burst_w, wt_w;

  // result beat
  logic                 res_valid_q;
  logic [1:0]           status_q;
  logic                 idle_q, done_q;
  logic [PID_W-1:0]     run_out_q, done_pid_q;
  logic [OUT_T_W-1:0]   wt_q, ta_q, now_q;

  assign q_eff     = (quantum_i == '0) ? QUANTUM_W'(1) : quantum_i;
  assign preempt   = run_valid_q && (slice_q >= q_eff) && (run_rem_q != '0);
  assign fifo_full = (count_q == CW'(MAX_PROCS));
  assign sts_o.pop_needed = (!run_valid_q || preempt) &&
                            ((count_q != '0) || (preempt && !fifo_full));

  assign pid_idx  = PW'(pid_i);
  assign pid_ok   = (32'(pid_i) < MAX_PROCS);
  assign dup      = !pid_ok || admitted_q[pid_idx];
  assign admit_ok = cmd_i.admit && !dup && (burst_i != '0);

  assign fifo_we    = !fifo_full && (admit_ok || (cmd_i.tick && preempt));
  assign fifo_wdata = cmd_i.admit ? pid_idx : run_pid_q;

  assign tab_we    = admit_ok || (cmd_i.tick && preempt);
  assign tab_waddr = cmd_i.admit ? pid_idx : run_pid_q;
  assign tab_wdata = cmd_i.admit ? {clock_q, burst_i, burst_i}
                                 : {run_arr_q, run_burst_q, run_rem_q};

  rrqs_ram #(.WIDTH(PW), .DEPTH(MAX_PROCS)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (tail_q),
    .wdata_i (fifo_wdata),
    .re_i    (cmd_i.fetch_head),
    .raddr_i (head_q),
    .rdata_o (fifo_rdata)
  );

  rrqs_ram #(.WIDTH(EW), .DEPTH(MAX_PROCS)) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .re_i    (cmd_i.fetch_entry),
    .raddr_i (fifo_rdata),
    .rdata_o (tab_rdata)
  );

  assign clock_d  = (clock_q == '1) ? clock_q : clock_q + TIME_BITS'(1);
  assign rem_next = (run_rem_q != '0) ? run_rem_q - BURST_W'(1) : run_rem_q;
  assign finish   = run_valid_q && (rem_next == '0);
  assign ta       = clock_d - run_arr_q;
  assign ta_w     = WW'(ta);
  assign burst_w  = WW'(run_burst_q);
  assign wt_w     = (ta_w >= burst_w) ? ta_w - burst_w : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      admitted_q  <= '0;
      clock_q     <= '0;
      run_valid_q <= 1'b0;
      run_pid_q   <= '0;
      slice_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.admit || cmd_i.execute;
      if (fifo_we) begin
        tail_q  <= (tail_q == PW'(MAX_PROCS - 1)) ? '0 : tail_q + PW'(1);
        count_q <= count_q + CW'(1);
      end else if (cmd_i.fetch_head) begin
        head_q  <= (head_q == PW'(MAX_PROCS - 1)) ? '0 : head_q + PW'(1);
        count_q <= count_q - CW'(1);
      end
      if (admit_ok) begin
        admitted_q[pid_idx] <= 1'b1;
      end
      if (cmd_i.tick && preempt) begin
        run_valid_q <= 1'b0;
      end
      if (cmd_i.fetch_entry) begin
        run_pid_q <= fifo_rdata;
      end
      if (cmd_i.load_entry) begin
        run_valid_q <= 1'b1;
        slice_q     <= '0;
      end
      if (cmd_i.execute) begin
        clock_q <= clock_d;
        if (run_valid_q) begin
          if (finish) begin
            run_valid_q           <= 1'b0;
            admitted_q[run_pid_q] <= 1'b0;
            slice_q               <= '0;
          end else if (slice_q != '1) begin
            slice_q <= slice_q + SLICE_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_entry) begin
      run_arr_q   <= tab_rdata[EW-1 -: TIME_BITS];
      run_burst_q <= tab_rdata[2*BURST_W-1 -: BURST_W];
      run_rem_q   <= tab_rdata[BURST_W-1:0];
    end else if (cmd_i.execute && run_valid_q) begin
      run_rem_q <= rem_next;
    end
    if (cmd_i.admit) begin
      status_q   <= dup ? ST_DUPLICATE : ((burst_i == '0) ? ST_ZERO_BURST : ST_ACCEPT);
      idle_q     <= 1'b0;
      run_out_q  <= '0;
      done_q     <= 1'b0;
      done_pid_q <= '0;
      wt_q       <= '0;
      ta_q       <= '0;
      now_q      <= OUT_T_W'(clock_q);
    end else if (cmd_i.execute) begin
      status_q   <= ST_TICK;
      idle_q     <= !run_valid_q;
      run_out_q  <= run_valid_q ? PID_W'(run_pid_q) : '0;
      done_q     <= finish;
      done_pid_q <= finish ? PID_W'(run_pid_q) : '0;
      wt_q       <= finish ? OUT_T_W'(wt_w) : '0;
      ta_q       <= finish ? OUT_T_W'(ta) : '0;
      now_q      <= OUT_T_W'(clock_d);
    end
  end

  assign res_valid_o       = res_valid_q;
  assign admit_status_o    = status_q;
  assign idle_o            = idle_q;
  assign run_pid_o         = run_out_q;
  assign done_res_o        = done_q;
  assign done_pid_o        = done_pid_q;
  assign waiting_time_o    = wt_q;
  assign turnaround_time_o = ta_q;
  assign now_o             = now_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_PROCS))
    else $error("ready queue count beyond capacity");

  a_run_admitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q |-> admitted_q[run_pid_q])
    else $error("running process not marked admitted");

  a_beat_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(cmd_i.admit || cmd_i.execute))
    else $error("result beat without admit or execute");

  a_dispatch_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_entry |=> run_valid_q)
    else $error("dispatch did not start a process");
`endif

endmodule

/* rtl/round_robin_quantum_scheduler_core.sv */
// Top level of the round-robin quantum scheduler: APB quantum register,
// sequencer and datapath. Depends on rrqs_pkg, rrqs_ctrl and rrqs_datapath.
//
// An admit item leaves busy low and its result beat follows on the next cycle.
// A tick goes straight to the execute step when no dispatch is needed; when the
// head of the ready queue is dispatched it first does a queue RAM read, then a
// process-table RAM read, then loading the running context, then the execute
// step. The result beat of a tick appears the cycle after its execute step and
// busy is low in that same cycle. Each result is shown for exactly one cycle
// on res_valid_o and cannot be stalled. Write the quantum only while idle.
module round_robin_quantum_scheduler_core import rrqs_pkg::*; #(
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 start,
  input  logic                 func_i,
  input  logic [PID_W-1:0]     pid_i,
  input  logic [BURST_W-1:0]   burst_i,
  output logic                 busy,
  output logic                 res_valid_o,
  output logic [1:0]           admit_status_o,
  output logic                 idle_o,
  output logic [PID_W-1:0]     run_pid_o,
  output logic                 done_res_o,
  output logic [PID_W-1:0]     done_pid_o,
  output logic [OUT_T_W-1:0]   waiting_time_o,
  output logic [OUT_T_W-1:0]   turnaround_time_o,
  output logic [OUT_T_W-1:0]   now_o
);

  logic [QUANTUM_W-1:0] quantum_q;
  logic                 cfg_wr;
  cmd_t                 cmd;
  sts_t                 sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_QUANTUM);
  assign prdata = (paddr[2] == REG_QUANTUM) ? 32'(quantum_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RESET;
    end else if (cfg_wr) begin
      quantum_q <= pwdata[QUANTUM_W-1:0];
    end
  end

  rrqs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  rrqs_datapath #(.MAX_PROCS(MAX_PROCS), .TIME_BITS(TIME_BITS)) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .pid_i            (pid_i),
    .burst_i          (burst_i),
    .quantum_i        (quantum_q),
    .sts_o            (sts),
    .res_valid_o      (res_valid_o),
    .admit_status_o   (admit_status_o),
    .idle_o           (idle_o),
    .run_pid_o        (run_pid_o),
    .done_res_o       (done_res_o),
    .done_pid_o       (done_pid_o),
    .waiting_time_o   (waiting_time_o),
    .turnaround_time_o(turnaround_time_o),
    .now_o            (now_o)
  );

endmodule

/* tb/tb_round_robin_quantum_scheduler_core.sv */
// Self-checking testbench for round_robin_quantum_scheduler_core: random and directed
// admit/tick beats with an in-bench scheduler predictor, APB quantum writes between phases.
// Depends on rrqs_pkg and the RTL of the scheduler core.
module tb_round_robin_quantum_scheduler_core;
  import rrqs_pkg::*;

  localparam int unsigned NPROC       = 16;
  localparam int unsigned REG_SPARE   = 1;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic               func;
    logic [PID_W-1:0]   pid;
    logic [BURST_W-1:0] burst;
  } sched_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               idle;
    logic [PID_W-1:0]   run_pid;
    logic               done;
    logic [PID_W-1:0]   done_pid;
    logic [OUT_T_W-1:0] wait_t;
    logic [OUT_T_W-1:0] turn_t;
    logic [OUT_T_W-1:0] now;
  } sched_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               func_i = FUNC_ADMIT;
  logic [PID_W-1:0]   pid_i = '0;
  logic [BURST_W-1:0] burst_i = '0;
  logic               busy;
  logic               res_valid_o;
  logic [1:0]         admit_status_o;
  logic               idle_o;
  logic [PID_W-1:0]   run_pid_o;
  logic               done_res_o;
  logic [PID_W-1:0]   done_pid_o;
  logic [OUT_T_W-1:0] waiting_time_o;
  logic [OUT_T_W-1:0] turnaround_time_o;
  logic [OUT_T_W-1:0] now_o;

  round_robin_quantum_scheduler_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .start             (start),
    .func_i            (func_i),
    .pid_i             (pid_i),
    .burst_i           (burst_i),
    .busy              (busy),
    .res_valid_o       (res_valid_o),
    .admit_status_o    (admit_status_o),
    .idle_o            (idle_o),
    .run_pid_o         (run_pid_o),
    .done_res_o        (done_res_o),
    .done_pid_o        (done_pid_o),
    .waiting_time_o    (waiting_time_o),
    .turnaround_time_o (turnaround_time_o),
    .now_o             (now_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scheduler state as the predictor sees it
  logic [QUANTUM_W-1:0] sched_quantum = QUANTUM_RESET;
  logic [OUT_T_W-1:0]   sched_clock = '0;
  logic [PID_W-1:0]     ready_ring [NPROC];
  logic [PID_W-1:0]     ring_head = '0;
  logic [PID_W-1:0]     ring_tail = '0;
  logic [PID_W:0]       ring_count = '0;
  logic [OUT_T_W-1:0]   arrive_at [NPROC];
  logic [BURST_W-1:0]   burst_len [NPROC];
  logic [BURST_W-1:0]   work_left [NPROC];
  logic [NPROC-1:0]     pid_live = '0;
  logic [PID_W-1:0]     cur_pid = '0;
  logic                 cur_on = 1'b0;
  logic [SLICE_W-1:0]   slice_cnt = '0;

  sched_item_t pending_items [$];
  sched_res_t  sched_expect_q [$];
  sched_item_t next_item;
  sched_res_t  due;

  int err_count = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_done = 0;
  int n_idle = 0;
  int n_reject = 0;
  int n_qwrites = 0;
  int send_left = 1;
  int gap_left = 0;
  int stall_cycles = 0;

  function automatic void ready_push(input logic [PID_W-1:0] p);
    if (ring_count < NPROC) begin
      ready_ring[ring_tail] = p;
      ring_tail++;
      ring_count++;
    end
  endfunction

  function automatic sched_res_t schedule_item(input sched_item_t it);
    sched_res_t         r;
    logic [OUT_T_W-1:0] ta;
    r = '0;
    if (it.func == FUNC_ADMIT) begin
      if (pid_live[it.pid]) begin
        r.status = ST_DUPLICATE;
        n_reject++;
      end else if (it.burst == '0) begin
        r.status = ST_ZERO_BURST;
        n_reject++;
      end else begin
        pid_live[it.pid] = 1'b1;
        arrive_at[it.pid] = sched_clock;
        burst_len[it.pid] = it.burst;
        work_left[it.pid] = it.burst;
        ready_push(it.pid);
        r.status = ST_ACCEPT;
      end
      r.now = sched_clock;
      return r;
    end
    r.status = ST_TICK;
    if (cur_on && slice_cnt >= sched_quantum && work_left[cur_pid] != '0) begin
      ready_push(cur_pid);
      cur_on = 1'b0;
    end
    if (!cur_on && ring_count != '0) begin
      cur_pid = ready_ring[ring_head];
      ring_head++;
      ring_count--;
      cur_on = 1'b1;
      slice_cnt = '0;
    end
    if (sched_clock != '1) sched_clock++;
    if (cur_on) begin
      r.run_pid = cur_pid;
      if (work_left[cur_pid] != '0) work_left[cur_pid]--;
      if (slice_cnt != '1) slice_cnt++;
      if (work_left[cur_pid] == '0) begin
        ta = sched_clock - arrive_at[cur_pid];
        r.done = 1'b1;
        r.done_pid = cur_pid;
        r.turn_t = ta;
        r.wait_t = (ta >= burst_len[cur_pid]) ? ta - burst_len[cur_pid] : '0;
        cur_on = 1'b0;
        pid_live[cur_pid] = 1'b0;
        slice_cnt = '0;
        n_done++;
      end
    end else begin
      r.idle = 1'b1;
      n_idle++;
    end
    r.now = sched_clock;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // driver: bursts of beats with random gaps, hold while busy
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        sched_expect_q.push_back(schedule_item('{func_i, pid_i, burst_i}));
        n_items++;
      end
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          func_i <= next_item.func;
          pid_i <= next_item.pid;
          burst_i <= next_item.burst;
          start <= 1'b1;
          if (send_left <= 1) begin
            send_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            send_left <= send_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (sched_expect_q.size() == 0) begin
        $error("result beat with no expectation pending");
        err_count++;
      end else begin
        due = sched_expect_q.pop_front();
        check_field("admit_status", 16'(due.status), 16'(admit_status_o));
        check_field("idle", 16'(due.idle), 16'(idle_o));
        check_field("run_pid", 16'(due.run_pid), 16'(run_pid_o));
        check_field("done_res", 16'(due.done), 16'(done_res_o));
        check_field("done_pid", 16'(due.done_pid), 16'(done_pid_o));
        check_field("waiting_time", due.wait_t, waiting_time_o);
        check_field("turnaround_time", due.turn_t, turnaround_time_o);
        check_field("now", due.now, now_o);
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("tb_round_robin_quantum_scheduler_core: done, errors");
        $finish;
      end
    end
  end

  task automatic add_admit(input logic [PID_W-1:0] p, input logic [BURST_W-1:0] b);
    pending_items.push_back('{FUNC_ADMIT, p, b});
  endtask

  task automatic add_tick(input int n);
    for (int i = 0; i < n; i++)
      pending_items.push_back('{FUNC_TICK, PID_W'($urandom), BURST_W'($urandom)});
  endtask

  task automatic queue_random(input int n);
    int                 admit_pct;
    int                 pick;
    logic [BURST_W-1:0] b;
    admit_pct = 20;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(3))
          0: admit_pct = 8;
          1: admit_pct = 20;
          2: admit_pct = 35;
          default: admit_pct = 60;
        endcase
      end
      if ($urandom_range(99) < admit_pct) begin
        pick = $urandom_range(99);
        if (pick < 5) b = '0;
        else if (pick < 75) b = BURST_W'($urandom_range(1, 6));
        else if (pick < 99) b = BURST_W'($urandom_range(7, 40));
        else b = BURST_W'($urandom);
        add_admit(PID_W'($urandom_range(NPROC - 1)), b);
      end else begin
        add_tick(1);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || start || sched_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_quantum_reg(input int unsigned idx, input logic [31:0] data);
    logic [31:0] seen;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx * 4);
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_QUANTUM) sched_quantum = data[QUANTUM_W-1:0];
    n_qwrites++;
    @(posedge clk_i);
    psel <= 1'b1;
    paddr <= {REG_QUANTUM, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    seen = prdata;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (seen !== 32'(sched_quantum)) begin
      $error("quantum readback: expected %0d, got %0d", sched_quantum, seen);
      err_count++;
    end
    @(negedge clk_i);
  endtask

  initial begin
    logic [31:0] q_writes [6];
    q_writes = '{32'd1, 32'd255, 32'd0, 32'hFFFF_FF03, 32'd2, 32'd4};
    q_writes[4] = $urandom_range(5, 254);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty tick, rejects, preemption behind later admits, pid reuse
    add_tick(1);
    add_admit(0, 0);
    add_admit(0, 6);
    add_admit(0, 0);
    add_admit(0, 16'hFFFF);
    add_tick(2);
    add_admit(15, 2);
    add_admit(7, 1);
    add_tick(10);
    add_admit(0, 1);
    add_tick(1);
    wait_drained();

    for (int k = 0; k < 6; k++) begin
      if (k == 2) set_quantum_reg(REG_SPARE, 32'h0000_00AA);
      set_quantum_reg(REG_QUANTUM, q_writes[k]);
      queue_random(172);
      wait_drained();
    end

    if (sched_expect_q.size() != 0) begin
      $error("%0d expected results never arrived", sched_expect_q.size());
      err_count++;
    end
    $display("covered %0d beats in, %0d results checked, %0d completions, %0d idle ticks",
             n_items, n_checked, n_done, n_idle);
    $display("%0d rejected admits, %0d register writes, clock ended at %0d",
             n_reject, n_qwrites, sched_clock);
    if (err_count == 0) begin
      $display("tb_round_robin_quantum_scheduler_core: done, clean");
    end else begin
      $display("tb_round_robin_quantum_scheduler_core: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rrqs_pkg.sv
rtl/rrqs_ram.sv
rtl/rrqs_ctrl.sv
rtl/rrqs_datapath.sv
rtl/round_robin_quantum_scheduler_core.sv
tb/tb_round_robin_quantum_scheduler_core.sv
